// ===== src/at_response_recognizer_defines.svh =====
// Assertion macros for the AT response recogniser.
// Each check is sampled on the rising clock edge and is switched off while in reset.
`ifndef AT_RESPONSE_RECOGNIZER_DEFINES_SVH
`define AT_RESPONSE_RECOGNIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that the antecedent implies the consequent in the same cycle.
`define AT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the antecedent implies the consequent in the next cycle.
`define AT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define AT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/at_resp_pkg.sv =====
`default_nettype none

package at_resp_pkg;

    // Operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Outcome codes
    localparam logic [1:0] OUT_OK      = 2'd0;
    localparam logic [1:0] OUT_ERROR   = 2'd1;
    localparam logic [1:0] OUT_TIMEOUT = 2'd2;

    // Characters that the matchers use
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] NUL_BYTE  = 8'h00;
    localparam logic [7:0] CHAR_O    = 8'h4F;
    localparam logic [7:0] CHAR_K    = 8'h4B;
    localparam logic [7:0] CHAR_E    = 8'h45;
    localparam logic [7:0] CHAR_R    = 8'h52;
    localparam logic [7:0] CHAR_COLN = 8'h3A;

    // Length of "OK", and last position of "ERROR:"
    localparam logic [1:0] OK_DONE   = 2'd2;
    localparam logic [2:0] ERR_LAST  = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_FOUND = 2'd2
    } t_phase;

    // Result of one processed request
    typedef struct packed {
        logic       valid;
        logic [1:0] outcome;
    } t_result;

    // Character of "OK" at a position
    function automatic logic [7:0] ok_char(input logic pos);
        return pos ? CHAR_K : CHAR_O;
    endfunction

    // Character of "ERROR:" at a position
    function automatic logic [7:0] err_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CHAR_E;
            3'd1:    c = CHAR_R;
            3'd2:    c = CHAR_R;
            3'd3:    c = CHAR_O;
            3'd4:    c = CHAR_R;
            default: c = CHAR_COLN;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/at_resp_core.sv =====
`default_nettype none

module at_resp_core import at_resp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [7:0] i_timeout_ticks,
    output t_result         o_result
);

    t_phase     r_phase, n_phase;
    logic [1:0] r_ok, n_ok;
    logic [2:0] r_err, n_err;
    logic [7:0] r_elapsed, n_elapsed;
    logic [7:0] r_limit, n_limit;

    logic [1:0] ok_next;
    logic       ok_hit;
    logic [2:0] err_pos;
    logic [2:0] err_next;
    logic       err_hit;
    logic [7:0] tick_next;
    logic       active;

    assign active = (r_phase == PH_WAIT) || (r_phase == PH_FOUND);

    // Advance the "OK" matcher
    always_comb begin
        ok_next = r_ok;
        ok_hit  = 1'b0;
        if (r_ok < OK_DONE) begin
            if (i_rx_byte == ok_char(r_ok[0])) begin
                ok_next = r_ok + 2'd1;
                ok_hit  = (ok_next == OK_DONE);
            end else begin
                ok_next = (i_rx_byte == CHAR_O) ? 2'd1 : 2'd0;
            end
        end
    end

    // Advance the "ERROR:" matcher
    always_comb begin
        err_pos  = (r_err > ERR_LAST) ? 3'd0 : r_err;
        err_next = 3'd0;
        err_hit  = 1'b0;
        if (i_rx_byte == err_char(err_pos)) begin
            if (err_pos == ERR_LAST) begin
                err_hit = 1'b1;
            end else begin
                err_next = err_pos + 3'd1;
            end
        end else begin
            err_next = (i_rx_byte == CHAR_E) ? 3'd1 : 3'd0;
        end
    end

    // Saturating tick count
    assign tick_next = (r_elapsed != 8'hFF) ? (r_elapsed + 8'd1) : r_elapsed;

    // Next exchange state and result
    always_comb begin
        n_phase          = r_phase;
        n_ok             = r_ok;
        n_err            = r_err;
        n_elapsed        = r_elapsed;
        n_limit          = r_limit;
        o_result.valid   = 1'b0;
        o_result.outcome = OUT_OK;
        if (i_step) begin
            unique case (i_operation)
                OP_START: begin
                    n_phase   = PH_IDLE;
                    n_ok      = 2'd0;
                    n_err     = 3'd0;
                    n_elapsed = 8'd0;
                    n_limit   = 8'd0;
                    if (i_timeout_ticks == 8'd0) begin
                        o_result.valid   = 1'b1;
                        o_result.outcome = OUT_TIMEOUT;
                    end else begin
                        n_limit = i_timeout_ticks;
                        n_phase = PH_WAIT;
                    end
                end
                OP_TICK: begin
                    if (active) begin
                        if (tick_next >= r_limit) begin
                            n_phase          = PH_IDLE;
                            n_ok             = 2'd0;
                            n_err            = 3'd0;
                            n_elapsed        = 8'd0;
                            n_limit          = 8'd0;
                            o_result.valid   = 1'b1;
                            o_result.outcome = OUT_TIMEOUT;
                        end else begin
                            n_elapsed = tick_next;
                        end
                    end
                end
                OP_BYTE: begin
                    if (active && (i_rx_byte != NUL_BYTE)) begin
                        if (r_phase == PH_WAIT) begin
                            n_ok  = ok_next;
                            n_err = err_next;
                            if (ok_hit || err_hit) begin
                                n_phase = PH_FOUND;
                            end
                        end else if (i_rx_byte == CR_BYTE) begin
                            o_result.valid   = 1'b1;
                            o_result.outcome = (r_ok == OK_DONE) ? OUT_OK : OUT_ERROR;
                            n_phase          = PH_IDLE;
                            n_ok             = 2'd0;
                            n_err            = 3'd0;
                            n_elapsed        = 8'd0;
                            n_limit          = 8'd0;
                        end else begin
                            n_ok = ok_next;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the exchange state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_ok      <= 2'd0;
            r_err     <= 3'd0;
            r_elapsed <= 8'd0;
            r_limit   <= 8'd0;
        end else begin
            r_phase   <= n_phase;
            r_ok      <= n_ok;
            r_err     <= n_err;
            r_elapsed <= n_elapsed;
            r_limit   <= n_limit;
        end
    end

endmodule

`default_nettype wire

// ===== src/at_response_recognizer.sv =====
// AT response recogniser: watches a modem's receive stream and reports the final result
// code of each exchange. A start request opens an exchange with a timeout in ticks. Byte
// requests feed matchers for "OK" and "ERROR:", and the carriage return after a match
// closes the exchange with OK (if "OK" was seen) or ERROR. Tick requests count towards
// the timeout, and reaching it closes the exchange with TIMEOUT. A start with a timeout
// of zero gives TIMEOUT at once. Requests pass through an input register and then the
// matcher update into a result register. One request is taken every cycle unless a
// waiting result holds a request in the input register. A result stays in the result
// register until it is taken. While a result waits, the next registered request waits as
// well, and the input register then holds one request.
`default_nettype none

`include "at_response_recognizer_defines.svh"

module at_response_recognizer import at_resp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [7:0] i_timeout_ticks,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_outcome
);

    logic       r_in_valid;
    logic [1:0] r_operation;
    logic [7:0] r_rx_byte;
    logic [7:0] r_timeout_ticks;
    logic       r_out_valid;
    logic [1:0] r_outcome;

    logic       advance;
    t_result    result;

    // Process the registered request when the result slot is free or being emptied
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // Register the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_operation     <= i_operation;
            r_rx_byte       <= i_rx_byte;
            r_timeout_ticks <= i_timeout_ticks;
        end
    end

    at_resp_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_operation     (r_operation),
        .i_rx_byte       (r_rx_byte),
        .i_timeout_ticks (r_timeout_ticks),
        .o_result        (result)
    );

    // Load a new result, or drop the one that was taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_outcome <= result.outcome;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_outcome = r_outcome;

    `AT_ASSERT_IMPL(a_stall_holds_item, i_clk, i_rst_n, !o_ready, r_in_valid)
    `AT_ASSERT_NEXT(a_item_kept, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid)
    `AT_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, result.valid, !r_out_valid || i_ready)

endmodule

`default_nettype wire
